### design/fca_pkg.sv
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types, constants and helper functions of the FAT16 cluster
// allocator: request and result formats, queue entry, configuration bundle.
// ----------------------------------------------------------------------------
package fca_pkg;

  // Table geometry.
  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned ADDR_W        = $clog2(TABLE_ENTRIES);

  // Fixed field widths of the request and result.
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned CLUSTER_W = 12;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned STATUS_W  = 2;

  // Range limits need one bit more than the widest cluster number.
  localparam int unsigned LIM_W  = (ADDR_W > CLUSTER_W) ? ADDR_W + 1 : CLUSTER_W + 1;
  localparam int unsigned WIDE_W = (LIM_W > DATA_W) ? LIM_W : DATA_W;

  // First cluster number that maps to data.
  localparam int unsigned FIRST_CLUSTER = 2;

  // Request queue depth between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Action codes on the request.
  typedef enum logic [ACTION_W-1:0] {
    ACT_READ  = 3'd0,
    ACT_WRITE = 3'd1,
    ACT_ALLOC = 3'd2,
    ACT_FREE  = 3'd3,
    ACT_HINT  = 3'd4
  } action_e;

  // Status codes on the result.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_NO_SPACE = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_CLUSTER_TOTAL = 1'b0,
    REG_END_MARK      = 1'b1
  } cfg_reg_e;

  // Decoded operation carried through the queue.
  typedef enum logic [2:0] {
    OP_READ,
    OP_WRITE,
    OP_ALLOC,
    OP_FREE,
    OP_HINT,
    OP_BAD
  } op_e;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR
  } state_e;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [CLUSTER_W-1:0] cluster_num;
    logic [DATA_W-1:0]    entry_data;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [DATA_W-1:0]    read_value;
    logic [CLUSTER_W-1:0] granted_cluster;
  } rsp_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    op_e                  op;
    logic [CLUSTER_W-1:0] cluster;
    logic [DATA_W-1:0]    data;
    logic                 cluster_ok;
  } item_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  // Configuration bundle distributed from the top level.
  typedef struct packed {
    logic [CLUSTER_W-1:0] cluster_total;
    logic [DATA_W-1:0]    end_mark;
    logic [LIM_W-1:0]     lim;
  } cfg_t;

  // One past the last valid cluster, clamped to the table size.
  function automatic logic [LIM_W-1:0] range_end(input logic [CLUSTER_W-1:0] total);
    logic [LIM_W-1:0] sum;
    sum = LIM_W'(total) + LIM_W'(FIRST_CLUSTER);
    if (sum > LIM_W'(TABLE_ENTRIES)) begin
      sum = LIM_W'(TABLE_ENTRIES);
    end
    return sum;
  endfunction

  // True when a cluster number addresses a data cluster.
  function automatic logic in_range(input logic [WIDE_W-1:0] c,
                                    input logic [LIM_W-1:0]  lim);
    return (c >= WIDE_W'(FIRST_CLUSTER)) && (c < WIDE_W'(lim));
  endfunction

endpackage

### design/fca_front.sv
// ----------------------------------------------------------------------------
// fca_front
// Request front end: accepts requests, decodes the action, checks the
// cluster range and keeps the classified requests in a short queue.
// ----------------------------------------------------------------------------
module fca_front
  import fca_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  req_t   in_i,
  input  cfg_t   cfg_i,
  output qhead_t head_o,
  input  logic   pop_i
);

  item_t             q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              full;
  logic              push;
  item_t             item;

  // Decode the action and check the cluster range.
  always_comb begin
    item.cluster    = in_i.cluster_num;
    item.data       = in_i.entry_data;
    item.cluster_ok = in_range(WIDE_W'(in_i.cluster_num), cfg_i.lim);
    unique case (in_i.action)
      ACT_READ:  item.op = OP_READ;
      ACT_WRITE: item.op = OP_WRITE;
      ACT_ALLOC: item.op = OP_ALLOC;
      ACT_FREE:  item.op = OP_FREE;
      ACT_HINT:  item.op = OP_HINT;
      default:   item.op = OP_BAD;
    endcase
  end

  // Queue occupancy and pointers.
  assign full       = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign in_ready_o = en_i && !full;
  assign push       = in_valid_i && in_ready_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + (QPTR_W+1)'(1);
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wptr_q] <= item;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = q_mem[rptr_q];

endmodule

### design/fca_back.sv
// ----------------------------------------------------------------------------
// fca_back
// Request back end: owns the allocation table memory, clears it after
// reset, and carries out reads, writes, hint resets, next-fit allocation
// and chain freeing one request at a time into a result register.
// ----------------------------------------------------------------------------
module fca_back
  import fca_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  qhead_t head_i,
  output logic   pop_o,
  output logic   ready_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output rsp_t   out_o
);

  // Allocation table and its registered read data.
  logic [DATA_W-1:0] mem [TABLE_ENTRIES];
  logic [DATA_W-1:0] rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  state_e            state_q, state_d;
  item_t             cur_q, cur_d;
  logic [ADDR_W-1:0] init_q, init_d;
  logic [LIM_W-1:0]  hint_q, hint_d;
  logic [ADDR_W-1:0] scan_c_q, scan_c_d;
  logic [ADDR_W-1:0] chk_c_q, chk_c_d;
  logic              chk_vld_q, chk_vld_d;
  logic [LIM_W-1:0]  left_q, left_d;
  logic [DATA_W-1:0] chain_q, chain_d;
  logic [LIM_W-1:0]  guard_q, guard_d;
  logic              out_valid_q;
  rsp_t              out_q;

  logic              fin;
  rsp_t              res;
  logic              hint_stale;
  logic [LIM_W-1:0]  scan_nxt;

  assign hint_stale = (hint_q < LIM_W'(FIRST_CLUSTER)) || (hint_q >= cfg_i.lim);
  assign scan_nxt   = LIM_W'(scan_c_q) + LIM_W'(1);

  // Next state, memory port control and result.
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    init_d    = init_q;
    hint_d    = hint_q;
    scan_c_d  = scan_c_q;
    chk_c_d   = chk_c_q;
    chk_vld_d = chk_vld_q;
    left_d    = left_q;
    chain_d   = chain_q;
    guard_d   = guard_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    pop_o     = 1'b0;
    fin       = 1'b0;
    res.status          = STATUS_OK;
    res.read_value      = '0;
    res.granted_cluster = '0;

    unique case (state_q)
      // Clearing pass: one entry per cycle.
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_q;
        init_d    = init_q + ADDR_W'(1);
        if (init_q == ADDR_W'(TABLE_ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end

      // Take the next request once the result register can hold its result.
      S_IDLE: begin
        if (head_i.valid && (!out_valid_q || out_ready_i)) begin
          pop_o   = 1'b1;
          cur_d   = head_i.item;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (cur_q.op)
          OP_READ: begin
            if (cur_q.cluster_ok) begin
              mem_raddr = ADDR_W'(cur_q.cluster);
              state_d   = S_READ;
            end else begin
              fin        = 1'b1;
              res.status = STATUS_INVALID;
            end
          end
          OP_WRITE: begin
            fin = 1'b1;
            if (cur_q.cluster_ok) begin
              mem_we    = 1'b1;
              mem_waddr = ADDR_W'(cur_q.cluster);
              mem_wdata = cur_q.data;
            end else begin
              res.status = STATUS_INVALID;
            end
          end
          OP_ALLOC: begin
            scan_c_d  = hint_stale ? ADDR_W'(FIRST_CLUSTER) : ADDR_W'(hint_q);
            left_d    = cfg_i.lim - LIM_W'(FIRST_CLUSTER);
            chk_vld_d = 1'b0;
            if (cfg_i.lim <= LIM_W'(FIRST_CLUSTER)) begin
              fin        = 1'b1;
              res.status = STATUS_NO_SPACE;
            end else begin
              state_d = S_SCAN;
            end
          end
          OP_FREE: begin
            chain_d = DATA_W'(cur_q.cluster);
            guard_d = '0;
            state_d = S_FREE_RD;
          end
          OP_HINT: begin
            fin    = 1'b1;
            hint_d = LIM_W'(FIRST_CLUSTER);
          end
          default: begin
            fin        = 1'b1;
            res.status = STATUS_INVALID;
          end
        endcase
      end

      S_READ: begin
        fin            = 1'b1;
        res.read_value = rdata_q;
      end

      // Next-fit scan: one read issued per cycle, checked in the next cycle,
      // wrapping from the last cluster back to the first.
      S_SCAN: begin
        if (chk_vld_q && (rdata_q == '0)) begin
          fin                 = 1'b1;
          mem_we              = 1'b1;
          mem_waddr           = chk_c_q;
          mem_wdata           = cfg_i.end_mark;
          hint_d              = LIM_W'(chk_c_q) + LIM_W'(1);
          res.granted_cluster = CLUSTER_W'(chk_c_q);
        end else if (left_q == '0) begin
          fin        = 1'b1;
          res.status = STATUS_NO_SPACE;
        end else begin
          mem_raddr = scan_c_q;
          chk_c_d   = scan_c_q;
          chk_vld_d = 1'b1;
          left_d    = left_q - LIM_W'(1);
          scan_c_d  = (scan_nxt == cfg_i.lim) ? ADDR_W'(FIRST_CLUSTER) : ADDR_W'(scan_nxt);
        end
      end

      // Chain walk: check the link and read the entry it points to.
      S_FREE_RD: begin
        if (!in_range(WIDE_W'(chain_q), cfg_i.lim)) begin
          fin = 1'b1;
        end else if (guard_q > LIM_W'(cfg_i.cluster_total)) begin
          fin        = 1'b1;
          res.status = STATUS_INVALID;
        end else begin
          mem_raddr = ADDR_W'(chain_q);
          guard_d   = guard_q + LIM_W'(1);
          state_d   = S_FREE_WR;
        end
      end

      // Chain walk: free the entry and follow its link.
      S_FREE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(chain_q);
        mem_wdata = '0;
        chain_d   = rdata_q;
        state_d   = S_FREE_RD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = S_IDLE;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      init_q    <= '0;
      hint_q    <= LIM_W'(FIRST_CLUSTER);
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      init_q    <= init_d;
      hint_q    <= hint_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  // Work registers of the current request.
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    scan_c_q <= scan_c_d;
    chk_c_q  <= chk_c_d;
    left_q   <= left_d;
    chain_q  <= chain_d;
    guard_q  <= guard_d;
  end

  // Table memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign ready_o     = (state_q != S_INIT);

`ifndef SYNTH
  // A finishing request always finds the result register empty.
  a_fin_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> !out_valid_q)
    else $error("result overwritten before it was taken");

  // The hint stays within the table span.
  a_hint_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hint_q >= LIM_W'(FIRST_CLUSTER)) && (hint_q <= LIM_W'(TABLE_ENTRIES)))
    else $error("scan hint out of span");

  // Every freed entry was counted against the loop guard.
  a_free_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FREE_WR) |-> (guard_q != '0))
    else $error("chain entry freed without guard count");

  // The scan only ever checks valid cluster numbers.
  a_scan_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) && chk_vld_q) |->
      ((chk_c_q >= ADDR_W'(FIRST_CLUSTER)) && (LIM_W'(chk_c_q) < cfg_i.lim)))
    else $error("scan checked a cluster out of range");

  // No request leaves the queue during the clearing pass.
  a_init_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |=> !$past(pop_o))
    else $error("request taken during table clearing");
`endif

endmodule

### design/fat16_cluster_allocator_top.sv
// Sequencing: a hint reset, a write or a refused request finishes in the
// execute state; a read also waits for the registered table read; allocate
// runs the next-fit scan; free chain reads and frees one entry at a time.
// Requests run one at a time in the table sequencer; a 2-deep queue takes
// further requests while it works. After reset a clearing pass runs over
// all 4096 table entries.
// ----------------------------------------------------------------------------
// fat16_cluster_allocator_top
// FAT16 allocation table with next-fit cluster allocation, chain freeing and
// per-entry access, plus its two configuration registers.
// ----------------------------------------------------------------------------
module fat16_cluster_allocator_top
  import fca_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [DATA_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  req_t              in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rsp_t              out_o
);

  logic [CLUSTER_W-1:0] cluster_total_q;
  logic [DATA_W-1:0]    end_mark_q;
  cfg_t                 cfg;
  qhead_t               head;
  logic                 pop;
  logic                 back_ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_total_q <= CLUSTER_W'(4094);
      end_mark_q      <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CLUSTER_TOTAL: cluster_total_q <= cfg_wdata_i[CLUSTER_W-1:0];
        REG_END_MARK:      end_mark_q      <= cfg_wdata_i;
        default:           end_mark_q      <= end_mark_q;
      endcase
    end
  end

  assign cfg.cluster_total = cluster_total_q;
  assign cfg.end_mark      = end_mark_q;
  assign cfg.lim           = range_end(cluster_total_q);

  // Front end: accept, classify and queue.
  fca_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (back_ready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .cfg_i      (cfg),
    .head_o     (head),
    .pop_i      (pop)
  );

  // Back end: table memory and request sequencer.
  fca_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .head_i      (head),
    .pop_o       (pop),
    .ready_o     (back_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
